/* rtl/core/sla_pkg.sv */
// Package for the slice load admission table: operation and status codes,
// the cell command and chain word types, and shared constants. No dependencies.
`default_nettype none

package sla_pkg;

  localparam int unsigned Entries          = 16;
  localparam int unsigned KindW            = 3;
  localparam int unsigned SstW             = 8;
  localparam int unsigned SdW              = 24;
  localparam int unsigned CountW           = 16;
  localparam int unsigned JitterW          = 3;
  localparam int unsigned BaseW            = 8;
  localparam int unsigned BackoffW         = 9;
  localparam int unsigned StatusW          = 3;
  localparam logic [BaseW-1:0] BaseReset   = BaseW'(20);
  localparam int unsigned JitterSpan       = 6;
  localparam logic [JitterW-1:0] JitterMax = JitterW'(JitterSpan - 1);
  localparam logic [CountW-1:0] CountMax   = '1;

  typedef enum logic [KindW-1:0] {
    KIND_ADD    = 3'd0,
    KIND_REMOVE = 3'd1,
    KIND_INC    = 3'd2,
    KIND_DEC    = 3'd3,
    KIND_QUERY  = 3'd4,
    KIND_CHECK  = 3'd5
  } kind_e;

  typedef enum logic [StatusW-1:0] {
    STATUS_OK        = 3'd0,
    STATUS_NOT_FOUND = 3'd1,
    STATUS_FULL      = 3'd2,
    STATUS_ZERO      = 3'd3,
    STATUS_SATURATED = 3'd4
  } status_e;

  // Command broadcast to every cell; commit is high in the update cycle.
  typedef struct packed {
    logic              commit;
    logic [KindW-1:0]  kind;
    logic [SstW-1:0]   sst;
    logic [SdW-1:0]    sd;
    logic [CountW-1:0] threshold;
  } cmd_t;

  // Word handed from each cell to its right neighbor.
  typedef struct packed {
    logic              found;
    logic              free;
    logic [CountW-1:0] count;
    logic [CountW-1:0] limit;
  } chain_t;

endpackage

`default_nettype wire

/* rtl/core/sla_cell.sv */
// One table slot: key, UE count and threshold, with its own match and update.
// Depends on sla_pkg for the command and chain word types.
`default_nettype none

module sla_cell (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire sla_pkg::cmd_t   cmd_i,
  input  wire logic            any_found_i,
  input  wire sla_pkg::chain_t chain_i,
  output sla_pkg::chain_t      chain_o
);
  import sla_pkg::*;

  logic              valid_q, valid_d;
  logic [SstW-1:0]   sst_q, sst_d;
  logic [SdW-1:0]    sd_q, sd_d;
  logic [CountW-1:0] count_q, count_d;
  logic [CountW-1:0] limit_q, limit_d;
  logic              match;
  logic              claim;

  assign match = valid_q && (sst_q == cmd_i.sst) && (sd_q == cmd_i.sd);
  // This slot is the lowest free one when no slot to its left is free.
  assign claim = !valid_q && !chain_i.free;

  assign chain_o.found = chain_i.found | match;
  assign chain_o.free  = chain_i.free | !valid_q;
  assign chain_o.count = chain_i.count | (match ? count_q : '0);
  assign chain_o.limit = chain_i.limit | (match ? limit_q : '0);

  always_comb begin
    valid_d = valid_q;
    sst_d   = sst_q;
    sd_d    = sd_q;
    count_d = count_q;
    limit_d = limit_q;
    if (cmd_i.commit) begin
      unique case (kind_e'(cmd_i.kind))
        KIND_ADD: begin
          if (match || (!any_found_i && claim)) begin
            valid_d = 1'b1;
            sst_d   = cmd_i.sst;
            sd_d    = cmd_i.sd;
            count_d = '0;
            limit_d = cmd_i.threshold;
          end
        end
        KIND_REMOVE: begin
          if (match) begin
            valid_d = 1'b0;
          end
        end
        KIND_INC: begin
          if (match && (count_q != CountMax)) begin
            count_d = count_q + CountW'(1);
          end
        end
        KIND_DEC: begin
          if (match && (count_q != '0)) begin
            count_d = count_q - CountW'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sst_q   <= sst_d;
    sd_q    <= sd_d;
    count_q <= count_d;
    limit_q <= limit_d;
  end

endmodule

`default_nettype wire

/* rtl/core/slice_load_admission_table.sv */
// Top level of the slice load admission table: input capture, the row of
// slot cells, the check verdict and the result register. Depends on sla_pkg, sla_cell.
`default_nettype none

// Start is taken when busy is low; the row of cells resolves the key and
// updates itself in the next cycle, and the result is shown for one cycle with
// result_valid_o in the cycle after, when busy is already low again. The result
// cannot be held off, so it must be taken when shown. The user writes the backoff
// base register with backoff_base_we_i only while idle; the block does not check it.
module slice_load_admission_table #(
  parameter int unsigned ENTRIES = sla_pkg::Entries
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           start,
  output      logic                           busy,
  input  wire logic [sla_pkg::KindW-1:0]      kind_i,
  input  wire logic [sla_pkg::SstW-1:0]       sst_i,
  input  wire logic [sla_pkg::SdW-1:0]        sd_i,
  input  wire logic [sla_pkg::CountW-1:0]     threshold_i,
  input  wire logic [sla_pkg::JitterW-1:0]    jitter_i,
  input  wire logic                           last_i,
  input  wire logic                           backoff_base_we_i,
  input  wire logic [sla_pkg::BaseW-1:0]      backoff_base_i,
  output      logic                           result_valid_o,
  output      logic [sla_pkg::StatusW-1:0]    status_o,
  output      logic [sla_pkg::CountW-1:0]     load_count_o,
  output      logic                           reject_o,
  output      logic [sla_pkg::BackoffW-1:0]   backoff_o,
  output      logic                           done_res_o
);
  import sla_pkg::*;

  logic                busy_q;
  logic [KindW-1:0]    kind_q;
  logic [SstW-1:0]     sst_q;
  logic [SdW-1:0]      sd_q;
  logic [CountW-1:0]   threshold_q;
  logic [JitterW-1:0]  jitter_q;
  logic                last_q;
  logic [BaseW-1:0]    base_q;
  logic                pend_rej_q, pend_rej_d;
  logic [BackoffW-1:0] pend_boff_q, pend_boff_d;
  logic                res_valid_q;
  logic [StatusW-1:0]  status_q, status_d;
  logic [CountW-1:0]   count_q, count_d;
  logic                reject_q, reject_d;
  logic [BackoffW-1:0] boff_q, boff_d;
  logic                done_q, done_d;

  cmd_t                cmd;
  chain_t              chain [ENTRIES+1];
  chain_t              tail;
  logic [JitterW-1:0]  jitter_sat;
  logic [BackoffW-1:0] boff_new;

  assign cmd.commit    = busy_q;
  assign cmd.kind      = kind_q;
  assign cmd.sst       = sst_q;
  assign cmd.sd        = sd_q;
  assign cmd.threshold = threshold_q;
  assign chain[0]      = '0;
  assign tail          = chain[ENTRIES];

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    sla_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .cmd_i       (cmd),
      .any_found_i (tail.found),
      .chain_i     (chain[i]),
      .chain_o     (chain[i+1])
    );
  end

  assign jitter_sat = (jitter_q > JitterMax) ? JitterMax : jitter_q;
  assign boff_new   = BackoffW'(base_q) + BackoffW'(jitter_sat);

  always_comb begin
    status_d    = STATUS_OK;
    count_d     = '0;
    reject_d    = 1'b0;
    boff_d      = '0;
    done_d      = 1'b0;
    pend_rej_d  = pend_rej_q;
    pend_boff_d = pend_boff_q;
    unique case (kind_e'(kind_q))
      KIND_ADD: begin
        if (!tail.found && !tail.free) begin
          status_d = STATUS_FULL;
        end
      end
      KIND_REMOVE: begin
        if (!tail.found) begin
          status_d = STATUS_NOT_FOUND;
        end
      end
      KIND_INC: begin
        if (!tail.found) begin
          status_d = STATUS_NOT_FOUND;
        end else if (tail.count == CountMax) begin
          status_d = STATUS_SATURATED;
          count_d  = tail.count;
        end else begin
          count_d = tail.count + CountW'(1);
        end
      end
      KIND_DEC: begin
        if (!tail.found) begin
          status_d = STATUS_NOT_FOUND;
        end else if (tail.count == '0) begin
          status_d = STATUS_ZERO;
        end else begin
          count_d = tail.count - CountW'(1);
        end
      end
      KIND_QUERY: begin
        if (!tail.found) begin
          status_d = STATUS_NOT_FOUND;
        end else begin
          count_d = tail.count;
        end
      end
      KIND_CHECK: begin
        if (!tail.found) begin
          status_d = STATUS_NOT_FOUND;
        end else begin
          count_d = tail.count;
          if (!pend_rej_q && (tail.count >= tail.limit)) begin
            pend_rej_d  = 1'b1;
            pend_boff_d = boff_new;
          end
        end
        reject_d = pend_rej_d;
        boff_d   = pend_rej_d ? pend_boff_d : '0;
        done_d   = last_q;
        if (last_q) begin
          pend_rej_d  = 1'b0;
          pend_boff_d = '0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      res_valid_q <= 1'b0;
      base_q      <= BaseReset;
      pend_rej_q  <= 1'b0;
      pend_boff_q <= '0;
    end else begin
      busy_q      <= start && !busy_q;
      res_valid_q <= busy_q;
      if (backoff_base_we_i) begin
        base_q <= backoff_base_i;
      end
      if (busy_q) begin
        pend_rej_q  <= pend_rej_d;
        pend_boff_q <= pend_boff_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start && !busy_q) begin
      kind_q      <= kind_i;
      sst_q       <= sst_i;
      sd_q        <= sd_i;
      threshold_q <= threshold_i;
      jitter_q    <= jitter_i;
      last_q      <= last_i;
    end
    if (busy_q) begin
      status_q <= status_d;
      count_q  <= count_d;
      reject_q <= reject_d;
      boff_q   <= boff_d;
      done_q   <= done_d;
    end
  end

  assign busy           = busy_q;
  assign result_valid_o = res_valid_q;
  assign status_o       = status_q;
  assign load_count_o   = count_q;
  assign reject_o       = reject_q;
  assign backoff_o      = boff_q;
  assign done_res_o     = done_q;

endmodule

`default_nettype wire

/* tb/tb.sv */
// Self-checking testbench for slice_load_admission_table: directed table, a
// short counting run and constrained-by-hand random words, checked against an
// in-bench predictor or typed expected results. Depends on sla_pkg and the RTL top level.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sla_pkg::*;

  localparam int unsigned Period     = 10;
  localparam int unsigned CycleLimit = 1_000_000;
  localparam int unsigned DrainWait  = 4;
  localparam int unsigned PoolSize   = 24;
  localparam int unsigned PrintMax   = 100;

  localparam logic [KindW-1:0] KindSpare6 = 3'd6;
  localparam logic [KindW-1:0] KindSpare7 = 3'd7;

  typedef struct {
    logic [KindW-1:0]   kind;
    logic [SstW-1:0]    sst;
    logic [SdW-1:0]     sd;
    logic [CountW-1:0]  thr;
    logic [JitterW-1:0] jit;
    logic               last;
  } word_t;

  typedef struct {
    status_e             status;
    logic [CountW-1:0]   count;
    logic                reject;
    logic [BackoffW-1:0] backoff;
    logic                done;
  } slice_result_t;

  typedef struct {
    word_t         w;
    bit            typed;
    slice_result_t want;
  } directed_row_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  logic [KindW-1:0]     kind_i = '0;
  logic [SstW-1:0]      sst_i = '0;
  logic [SdW-1:0]       sd_i = '0;
  logic [CountW-1:0]    threshold_i = '0;
  logic [JitterW-1:0]   jitter_i = '0;
  logic                 last_i = 1'b0;
  logic                 backoff_base_we_i = 1'b0;
  logic [BaseW-1:0]     backoff_base_i = '0;
  logic                 result_valid_o;
  logic [StatusW-1:0]   status_o;
  logic [CountW-1:0]    load_count_o;
  logic                 reject_o;
  logic [BackoffW-1:0]  backoff_o;
  logic                 done_res_o;

  // Predictor state.
  logic                 tab_valid [Entries];
  logic [SstW-1:0]      tab_sst   [Entries];
  logic [SdW-1:0]       tab_sd    [Entries];
  logic [CountW-1:0]    tab_count [Entries];
  logic [CountW-1:0]    tab_limit [Entries];
  logic                 held_reject = 1'b0;
  logic [BackoffW-1:0]  held_backoff = '0;
  logic [BaseW-1:0]     base = BaseReset;

  logic [SstW-1:0]      pool_sst [PoolSize];
  logic [SdW-1:0]       pool_sd  [PoolSize];

  slice_result_t        awaited_results [$];
  slice_result_t        want_res;
  directed_row_t        directed_tab [$];
  int unsigned          error_count = 0;
  int unsigned          results_seen = 0;
  int unsigned          cycle_count = 0;
  int unsigned          idle_pct = 0;

  slice_load_admission_table #(
    .ENTRIES(Entries)
  ) i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .kind_i           (kind_i),
    .sst_i            (sst_i),
    .sd_i             (sd_i),
    .threshold_i      (threshold_i),
    .jitter_i         (jitter_i),
    .last_i           (last_i),
    .backoff_base_we_i(backoff_base_we_i),
    .backoff_base_i   (backoff_base_i),
    .result_valid_o   (result_valid_o),
    .status_o         (status_o),
    .load_count_o     (load_count_o),
    .reject_o         (reject_o),
    .backoff_o        (backoff_o),
    .done_res_o       (done_res_o)
  );

  always #(Period / 2) clk_i = ~clk_i;

  function automatic word_t wrd(logic [KindW-1:0] k, int unsigned a, int unsigned b,
                                int unsigned t, int unsigned j, int unsigned l);
    word_t w;
    w.kind = k;
    w.sst  = SstW'(a);
    w.sd   = SdW'(b);
    w.thr  = CountW'(t);
    w.jit  = JitterW'(j);
    w.last = l[0];
    return w;
  endfunction

  function automatic slice_result_t res(status_e st, int unsigned cnt, bit rej,
                                        int unsigned boff, bit done);
    slice_result_t r;
    r.status  = st;
    r.count   = CountW'(cnt);
    r.reject  = rej;
    r.backoff = BackoffW'(boff);
    r.done    = done;
    return r;
  endfunction

  function automatic slice_result_t predict_admission(word_t w);
    slice_result_t      r;
    int                 s;
    logic [JitterW-1:0] jit;
    r = res(STATUS_OK, 0, 1'b0, 0, 1'b0);
    s = -1;
    for (int i = 0; i < Entries; i++) begin
      if (s < 0 && tab_valid[i] && tab_sst[i] == w.sst && tab_sd[i] == w.sd) s = i;
    end
    case (w.kind)
      KIND_ADD: begin
        if (s < 0) begin
          for (int i = 0; i < Entries; i++) begin
            if (s < 0 && !tab_valid[i]) s = i;
          end
        end
        if (s < 0) begin
          r.status = STATUS_FULL;
        end else begin
          tab_valid[s] = 1'b1;
          tab_sst[s]   = w.sst;
          tab_sd[s]    = w.sd;
          tab_count[s] = '0;
          tab_limit[s] = w.thr;
        end
      end
      KIND_REMOVE: begin
        if (s < 0) r.status = STATUS_NOT_FOUND;
        else tab_valid[s] = 1'b0;
      end
      KIND_INC: begin
        if (s < 0) begin
          r.status = STATUS_NOT_FOUND;
        end else begin
          if (tab_count[s] == CountMax) r.status = STATUS_SATURATED;
          else tab_count[s] = tab_count[s] + CountW'(1);
          r.count = tab_count[s];
        end
      end
      KIND_DEC: begin
        if (s < 0) begin
          r.status = STATUS_NOT_FOUND;
        end else begin
          if (tab_count[s] == '0) r.status = STATUS_ZERO;
          else tab_count[s] = tab_count[s] - CountW'(1);
          r.count = tab_count[s];
        end
      end
      KIND_QUERY: begin
        if (s < 0) r.status = STATUS_NOT_FOUND;
        else r.count = tab_count[s];
      end
      KIND_CHECK: begin
        if (s < 0) begin
          r.status = STATUS_NOT_FOUND;
        end else begin
          r.count = tab_count[s];
          if (!held_reject && tab_count[s] >= tab_limit[s]) begin
            jit = (w.jit > JitterMax) ? JitterMax : w.jit;
            held_reject  = 1'b1;
            held_backoff = BackoffW'(base) + BackoffW'(jit);
          end
        end
        r.reject  = held_reject;
        r.backoff = held_reject ? held_backoff : '0;
        r.done    = w.last;
        if (w.last) begin
          held_reject  = 1'b0;
          held_backoff = '0;
        end
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  function automatic word_t keyed(logic [KindW-1:0] k);
    word_t       w;
    int unsigned p;
    p = $urandom_range(PoolSize - 1);
    w = wrd(k, 32'(pool_sst[p]), 32'(pool_sd[p]), $urandom, $urandom, $urandom);
    return w;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    if (error_count < PrintMax) begin
      $display("mismatch at result %0d: %s got %0h want %0h", results_seen, what, got, want);
    end
    error_count++;
  endtask

  task automatic send_word(word_t w, bit typed, slice_result_t want);
    slice_result_t predicted;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start       <= 1'b1;
    kind_i      <= w.kind;
    sst_i       <= w.sst;
    sd_i        <= w.sd;
    threshold_i <= w.thr;
    jitter_i    <= w.jit;
    last_i      <= w.last;
    do @(posedge clk_i); while (busy);
    predicted = predict_admission(w);
    awaited_results.push_back(typed ? want : predicted);
  endtask

  task automatic send_predicted(word_t w);
    send_word(w, 1'b0, res(STATUS_OK, 0, 1'b0, 0, 1'b0));
  endtask

  task automatic drain_and_set_base(logic [BaseW-1:0] v);
    start <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
    backoff_base_we_i <= 1'b1;
    backoff_base_i    <= v;
    @(posedge clk_i);
    backoff_base_we_i <= 1'b0;
    base = v;
  endtask

  task automatic random_stretch(int unsigned n);
    int unsigned sent;
    int unsigned r;
    int unsigned len;
    word_t       w;
    sent = 0;
    while (sent < n) begin
      r = $urandom_range(99);
      if (r < 22) begin
        w = keyed(KIND_ADD);
        if ($urandom_range(9) < 7) w.thr = CountW'($urandom_range(6));
        send_predicted(w);
        sent++;
      end else if (r < 32) begin
        send_predicted(keyed(KIND_REMOVE));
        sent++;
      end else if (r < 55) begin
        send_predicted(keyed(KIND_INC));
        sent++;
      end else if (r < 65) begin
        send_predicted(keyed(KIND_DEC));
        sent++;
      end else if (r < 72) begin
        send_predicted(keyed(KIND_QUERY));
        sent++;
      end else if (r < 92) begin
        len = $urandom_range(1, 4);
        for (int j = 0; j < len; j++) begin
          w = keyed(KIND_CHECK);
          if ($urandom_range(9) == 0) begin
            w.sst = SstW'($urandom);
            w.sd  = SdW'($urandom);
          end
          w.jit  = JitterW'($urandom_range(7));
          w.last = (j == len - 1);
          send_predicted(w);
          sent++;
        end
      end else if (r < 95) begin
        w = wrd($urandom_range(1) ? KindSpare7 : KindSpare6, $urandom, $urandom, $urandom,
                $urandom, $urandom);
        send_predicted(w);
      end else begin
        w = wrd(KindW'($urandom_range(KIND_CHECK)), $urandom, $urandom, $urandom, $urandom,
                $urandom);
        send_predicted(w);
        sent++;
      end
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      if (awaited_results.size() == 0) begin
        report_mismatch("word with nothing awaited", 32'd0, 32'd0);
      end else begin
        want_res = awaited_results.pop_front();
        if (status_o !== want_res.status)
          report_mismatch("status", 32'(status_o), 32'(want_res.status));
        if (load_count_o !== want_res.count)
          report_mismatch("load_count", 32'(load_count_o), 32'(want_res.count));
        if (reject_o !== want_res.reject)
          report_mismatch("reject", 32'(reject_o), 32'(want_res.reject));
        if (backoff_o !== want_res.backoff)
          report_mismatch("backoff", 32'(backoff_o), 32'(want_res.backoff));
        if (done_res_o !== want_res.done)
          report_mismatch("done_res", 32'(done_res_o), 32'(want_res.done));
      end
      results_seen++;
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("[slice_load_admission_table] ERROR");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < Entries; i++) begin
      tab_valid[i] = 1'b0;
      tab_sst[i]   = '0;
      tab_sd[i]    = '0;
      tab_count[i] = '0;
      tab_limit[i] = '0;
    end
    pool_sst[0] = '0;
    pool_sd[0]  = '0;
    pool_sst[1] = '1;
    pool_sd[1]  = '1;
    for (int p = 2; p < PoolSize; p++) begin
      pool_sst[p] = SstW'($urandom);
      pool_sd[p]  = ($urandom_range(3) == 0) ? '0 : SdW'($urandom);
    end

    directed_tab.push_back('{wrd(KIND_QUERY, 1, 0, 0, 0, 0), 1'b1,
                             res(STATUS_NOT_FOUND, 0, 0, 0, 0)});
    directed_tab.push_back('{wrd(KIND_REMOVE, 1, 0, 0, 0, 0), 1'b1,
                             res(STATUS_NOT_FOUND, 0, 0, 0, 0)});
    directed_tab.push_back('{wrd(KIND_ADD, 0, 0, 0, 0, 0), 1'b1,
                             res(STATUS_OK, 0, 0, 0, 0)});
    directed_tab.push_back('{wrd(KIND_CHECK, 0, 0, 0, 7, 0), 1'b1,
                             res(STATUS_OK, 0, 1, 25, 0)});
    directed_tab.push_back('{wrd(KIND_CHECK, 9, 9, 0, 0, 1), 1'b1,
                             res(STATUS_NOT_FOUND, 0, 1, 25, 1)});
    directed_tab.push_back('{wrd(KIND_INC, 0, 0, 0, 0, 0), 1'b1,
                             res(STATUS_OK, 1, 0, 0, 0)});
    directed_tab.push_back('{wrd(KIND_DEC, 0, 0, 0, 0, 0), 1'b1,
                             res(STATUS_OK, 0, 0, 0, 0)});
    directed_tab.push_back('{wrd(KIND_DEC, 0, 0, 0, 0, 0), 1'b1,
                             res(STATUS_ZERO, 0, 0, 0, 0)});
    directed_tab.push_back('{wrd(KIND_ADD, 255, 'hFFFFFF, 'hFFFF, 0, 0), 1'b1,
                             res(STATUS_OK, 0, 0, 0, 0)});
    directed_tab.push_back('{wrd(KIND_CHECK, 255, 'hFFFFFF, 0, 0, 1), 1'b1,
                             res(STATUS_OK, 0, 0, 0, 1)});
    directed_tab.push_back('{wrd(KIND_INC, 255, 'hFFFFFF, 0, 0, 0), 1'b0,
                             res(STATUS_OK, 0, 0, 0, 0)});
    directed_tab.push_back('{wrd(KIND_INC, 0, 0, 0, 0, 0), 1'b0,
                             res(STATUS_OK, 0, 0, 0, 0)});
    directed_tab.push_back('{wrd(KIND_ADD, 0, 0, 2, 0, 0), 1'b1,
                             res(STATUS_OK, 0, 0, 0, 0)});
    directed_tab.push_back('{wrd(KIND_QUERY, 0, 0, 0, 0, 0), 1'b1,
                             res(STATUS_OK, 0, 0, 0, 0)});
    directed_tab.push_back('{wrd(KIND_CHECK, 0, 0, 0, 2, 0), 1'b0,
                             res(STATUS_OK, 0, 0, 0, 0)});
    directed_tab.push_back('{wrd(KIND_INC, 0, 0, 0, 0, 0), 1'b0,
                             res(STATUS_OK, 0, 0, 0, 0)});
    directed_tab.push_back('{wrd(KIND_INC, 0, 0, 0, 0, 0), 1'b0,
                             res(STATUS_OK, 0, 0, 0, 0)});
    directed_tab.push_back('{wrd(KIND_CHECK, 255, 'hFFFFFF, 0, 1, 0), 1'b0,
                             res(STATUS_OK, 0, 0, 0, 0)});
    directed_tab.push_back('{wrd(KIND_CHECK, 0, 0, 0, 4, 1), 1'b0,
                             res(STATUS_OK, 0, 0, 0, 0)});
    directed_tab.push_back('{wrd(KindSpare6, 0, 0, 0, 0, 0), 1'b1,
                             res(STATUS_OK, 0, 0, 0, 0)});
    directed_tab.push_back('{wrd(KindSpare7, 255, 'hFFFFFF, 'hFFFF, 7, 1), 1'b1,
                             res(STATUS_OK, 0, 0, 0, 0)});
    directed_tab.push_back('{wrd(KIND_REMOVE, 0, 0, 0, 0, 0), 1'b1,
                             res(STATUS_OK, 0, 0, 0, 0)});
    directed_tab.push_back('{wrd(KIND_QUERY, 0, 0, 0, 0, 0), 1'b1,
                             res(STATUS_NOT_FOUND, 0, 0, 0, 0)});
    directed_tab.push_back('{wrd(KIND_REMOVE, 0, 0, 0, 0, 0), 1'b1,
                             res(STATUS_NOT_FOUND, 0, 0, 0, 0)});
    directed_tab.push_back('{wrd(KIND_CHECK, 0, 0, 0, 3, 1), 1'b1,
                             res(STATUS_NOT_FOUND, 0, 0, 0, 1)});

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    idle_pct = 16;
    foreach (directed_tab[n]) send_word(directed_tab[n].w, directed_tab[n].typed,
                                        directed_tab[n].want);

    // Count one slice up past its threshold, check it at the largest backoff and count down.
    drain_and_set_base('1);
    idle_pct = 0;
    send_predicted(wrd(KIND_ADD, 7, 'h5A5A5A, 10, 0, 0));
    repeat (12) send_predicted(wrd(KIND_INC, 7, 'h5A5A5A, 0, 0, 0));
    send_predicted(wrd(KIND_CHECK, 7, 'h5A5A5A, 0, 6, 1));
    send_predicted(wrd(KIND_DEC, 7, 'h5A5A5A, 0, 0, 0));
    send_predicted(wrd(KIND_REMOVE, 7, 'h5A5A5A, 0, 0, 0));

    drain_and_set_base('0);
    idle_pct = 16;
    random_stretch(330);

    drain_and_set_base(BaseW'($urandom));
    idle_pct = 82;
    random_stretch(330);

    drain_and_set_base('1);
    idle_pct = 0;
    random_stretch(330);

    start <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (error_count == 0) begin
      $display("[slice_load_admission_table] OK");
    end else begin
      $display("[slice_load_admission_table] ERROR");
    end
    $finish;
  end

endmodule
